FILE: src/mbsp_pkg.sv
// Shared types and codes for the MIDI byte stream parser.
package mbsp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_INPUT_ENABLE      = 2'd0;
    localparam logic [1:0] CFG_DEVICE_UNIT       = 2'd1;
    localparam logic [1:0] CFG_NOTE_OFF_VELOCITY = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_SENSE = 3'd3,
        KIND_VOICE = 3'd4,
        KIND_SYX   = 3'd5,
        KIND_ABORT = 3'd6
    } kind_t;

    // Wire byte codes
    localparam logic [7:0] BYTE_SYX_START = 8'hf0;
    localparam logic [7:0] BYTE_SYX_END   = 8'hf7;
    localparam logic [7:0] BYTE_TICK      = 8'hf8;
    localparam logic [7:0] BYTE_START     = 8'hfa;
    localparam logic [7:0] BYTE_STOP      = 8'hfc;
    localparam logic [7:0] BYTE_SENSE     = 8'hfe;

    // Voice command nibbles
    localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
    localparam logic [3:0] CMD_PROGRAM   = 4'hc;
    localparam logic [3:0] CMD_PRESSURE  = 4'hd;
    localparam logic [3:0] CMD_BEND      = 4'he;
    localparam logic [3:0] CMD_SYSTEM    = 4'hf;

    localparam int TDATA_W = 56;
    localparam int TUSER_W = 3;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  command;
        logic [3:0]  channel;
        logic [6:0]  value_a;
        logic [6:0]  value_b;
        logic [13:0] bend_value;
        logic [7:0]  sysex_byte;
        logic        sysex_last;
        logic [3:0]  device_number;
        logic        last_of_run;
    } result_t;

endpackage

FILE: src/midi_byte_stream_parser.sv
// MIDI byte stream parser: running-status decode of raw wire bytes into events.
//
// One MIDI wire byte enters per s_axis word and is decoded in the same cycle
// against the running status, the held first data byte and the open-sysex
// flag; its results land in a two-word output buffer. A byte that yields
// one result or none leaves the pending slot free, so a new byte is
// accepted every cycle while the output side keeps up. A sysex start
// that aborts an open sysex yields two results (abort, then F0); the second
// waits in a pending slot and input holds off until it drains. tlast marks
// the final result word caused by one input byte. Real-time bytes F8, FA,
// FC and FE are reported immediately without touching the parser state;
// other real-time bytes are dropped. A note-on with velocity 0 comes out as
// a note-off carrying note_off_velocity. With input_enable low, bytes are
// still taken but dropped with no effect. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata and must only change while the block is idle.
module midi_byte_stream_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [mbsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mbsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input byte stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] midi_byte
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] command, [7:4] channel, [14:8] value_a, [21:15] value_b,
    // [35:22] bend_value, [43:36] sysex_byte, [44] sysex_last,
    // [48:45] device_number, [55:49] zero
    output logic [mbsp_pkg::TDATA_W-1:0]    m_axis_tdata,
    output logic [mbsp_pkg::TUSER_W-1:0]    m_axis_tuser,   // [2:0] kind
    output logic                            m_axis_tlast    // last_of_run
);
    import mbsp_pkg::*;

    // configuration
    logic       input_enable_reg;
    logic [3:0] device_unit_reg;
    logic [6:0] note_off_velocity_reg;

    // parser state
    logic [7:0] running_status_reg, running_status_next;
    logic       data_held_reg, data_held_next;
    logic [6:0] first_data_reg, first_data_next;
    logic       sysex_open_reg, sysex_open_next;

    // output buffer: the presented word and one pending word
    logic    out_valid_reg;
    result_t out_word_reg;
    logic    pend_valid_reg;
    result_t pend_word_reg;

    // decode results
    logic    r0_valid, r1_valid;
    result_t r0, r1;

    logic       in_accept;
    logic       out_accept;
    logic [7:0] b;
    logic [3:0] rs_cmd;
    logic       need_two;
    logic [6:0] va, vb;

    function automatic result_t blank_result(kind_t k, logic [3:0] dev);
        result_t r;
        r               = '0;
        r.kind          = k;
        r.device_number = dev;
        return r;
    endfunction

    // accept only when both buffer slots will be free after this edge
    assign s_axis_tready = !pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = out_valid_reg && m_axis_tready;

    assign b        = s_axis_tdata;
    assign rs_cmd   = running_status_reg[7:4];
    assign need_two = !(rs_cmd == CMD_PROGRAM || rs_cmd == CMD_PRESSURE);

    always_comb
    begin
        running_status_next = running_status_reg;
        data_held_next      = data_held_reg;
        first_data_next     = first_data_reg;
        sysex_open_next     = sysex_open_reg;
        r0_valid            = 1'b0;
        r1_valid            = 1'b0;
        r0                  = blank_result(KIND_TICK, device_unit_reg);
        r1                  = blank_result(KIND_SYX, device_unit_reg);
        va                  = data_held_reg ? first_data_reg : b[6:0];
        vb                  = data_held_reg ? b[6:0] : 7'd0;

        if (input_enable_reg)
        begin
            if (b >= BYTE_TICK)
            begin
                // real-time: report the known ones, drop the rest
                unique case (b)
                    BYTE_TICK:
                    begin
                        r0_valid = 1'b1;
                        r0.kind  = KIND_TICK;
                    end
                    BYTE_START:
                    begin
                        r0_valid = 1'b1;
                        r0.kind  = KIND_START;
                    end
                    BYTE_STOP:
                    begin
                        r0_valid = 1'b1;
                        r0.kind  = KIND_STOP;
                    end
                    BYTE_SENSE:
                    begin
                        r0_valid = 1'b1;
                        r0.kind  = KIND_SENSE;
                    end
                    default:
                    begin
                        r0_valid = 1'b0;
                    end
                endcase
            end
            else if (b[7])
            begin
                running_status_next = b;
                data_held_next      = 1'b0;
                if (b == BYTE_SYX_START)
                begin
                    sysex_open_next = 1'b1;
                    if (sysex_open_reg)
                    begin
                        // abort the open sysex, then start a new one
                        r0_valid      = 1'b1;
                        r0            = blank_result(KIND_ABORT, device_unit_reg);
                        r1_valid      = 1'b1;
                        r1.sysex_byte = b;
                    end
                    else
                    begin
                        r0_valid      = 1'b1;
                        r0            = blank_result(KIND_SYX, device_unit_reg);
                        r0.sysex_byte = b;
                    end
                end
                else if (b == BYTE_SYX_END)
                begin
                    running_status_next = 8'd0;
                    if (sysex_open_reg)
                    begin
                        r0_valid        = 1'b1;
                        r0              = blank_result(KIND_SYX, device_unit_reg);
                        r0.sysex_byte   = b;
                        r0.sysex_last   = 1'b1;
                        sysex_open_next = 1'b0;
                    end
                end
                else if (sysex_open_reg)
                begin
                    r0_valid        = 1'b1;
                    r0              = blank_result(KIND_ABORT, device_unit_reg);
                    sysex_open_next = 1'b0;
                end
            end
            else if (running_status_reg[7] && rs_cmd != CMD_SYSTEM)
            begin
                if (!data_held_reg && need_two)
                begin
                    // hold the first of two data bytes
                    first_data_next = b[6:0];
                    data_held_next  = 1'b1;
                end
                else
                begin
                    data_held_next = 1'b0;
                    r0_valid       = 1'b1;
                    r0             = blank_result(KIND_VOICE, device_unit_reg);
                    r0.channel     = running_status_reg[3:0];
                    if (rs_cmd == CMD_NOTE_ON && vb == 7'd0)
                    begin
                        r0.command = CMD_NOTE_OFF;
                        r0.value_a = va;
                        r0.value_b = note_off_velocity_reg;
                    end
                    else if (rs_cmd == CMD_BEND)
                    begin
                        r0.command    = rs_cmd;
                        r0.bend_value = {vb, va};
                    end
                    else
                    begin
                        r0.command = rs_cmd;
                        r0.value_a = va;
                        r0.value_b = vb;
                    end
                end
            end
            else if (running_status_reg == BYTE_SYX_START && sysex_open_reg)
            begin
                r0_valid      = 1'b1;
                r0            = blank_result(KIND_SYX, device_unit_reg);
                r0.sysex_byte = b;
            end
        end

        // mark the final result of this byte
        r0.last_of_run = !r1_valid;
        r1.last_of_run = 1'b1;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_enable_reg      <= 1'b1;
            device_unit_reg       <= 4'd0;
            note_off_velocity_reg <= 7'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_INPUT_ENABLE:      input_enable_reg      <= cfg_wdata[0];
                CFG_DEVICE_UNIT:       device_unit_reg       <= cfg_wdata[3:0];
                CFG_NOTE_OFF_VELOCITY: note_off_velocity_reg <= cfg_wdata;
                default:               input_enable_reg      <= input_enable_reg;
            endcase
        end
    end

    // parser state and output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg <= 8'd0;
            data_held_reg      <= 1'b0;
            first_data_reg     <= 7'd0;
            sysex_open_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            pend_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                running_status_reg <= running_status_next;
                data_held_reg      <= data_held_next;
                first_data_reg     <= first_data_next;
                sysex_open_reg     <= sysex_open_next;
                out_valid_reg      <= r0_valid;
                pend_valid_reg     <= r1_valid;
            end
            else if (out_accept)
            begin
                // advance the pending word, if any
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_word_reg  <= r0;
            pend_word_reg <= r1;
        end
        else if (out_accept && pend_valid_reg)
        begin
            out_word_reg <= pend_word_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_word_reg.kind;
    assign m_axis_tlast  = out_word_reg.last_of_run;
    assign m_axis_tdata  = {7'd0,
                            out_word_reg.device_number,
                            out_word_reg.sysex_last,
                            out_word_reg.sysex_byte,
                            out_word_reg.bend_value,
                            out_word_reg.value_b,
                            out_word_reg.value_a,
                            out_word_reg.channel,
                            out_word_reg.command};

endmodule
